// ----- src/lmed_pkg.sv -----
// Shared types, constants and the luminance function for the 3x3 luma median select.
// No dependencies; every other file in the block uses this package.
`timescale 1ns / 1ps

package lmed_pkg;

    localparam int TAP_COUNT   = 9;
    localparam int PIX_W       = 24;
    localparam int CHAN_W      = 8;
    localparam int LUMA_W      = 18;
    localparam int RANK_W      = $clog2(TAP_COUNT);
    localparam int MEDIAN_RANK = 4;

    localparam logic [LUMA_W-1:0] K_RED   = LUMA_W'(299);
    localparam logic [LUMA_W-1:0] K_GREEN = LUMA_W'(587);
    localparam logic [LUMA_W-1:0] K_BLUE  = LUMA_W'(114);

    typedef logic [PIX_W-1:0]  t_pix;
    typedef logic [LUMA_W-1:0] t_luma;
    typedef logic [RANK_W-1:0] t_rank;

    typedef t_pix  [TAP_COUNT-1:0] t_pix_vec;
    typedef t_luma [TAP_COUNT-1:0] t_luma_vec;
    typedef logic  [TAP_COUNT-1:0] t_hit_vec;

    // 299*R + 587*G + 114*B; peaks at 255000, so 18 bits hold it
    function automatic t_luma luma_of(input t_pix p);
        t_luma r_term;
        t_luma g_term;
        t_luma b_term;
        r_term = LUMA_W'(p[23:16]) * K_RED;
        g_term = LUMA_W'(p[15:8])  * K_GREEN;
        b_term = LUMA_W'(p[7:0])   * K_BLUE;
        return r_term + g_term + b_term;
    endfunction

endpackage

// ----- src/lmed_if.sv -----
// Valid/ready channel interfaces for the window input and the median output.
// Depends on lmed_pkg for the pixel width.
`timescale 1ns / 1ps

interface lmed_win_if;
    logic                   valid;
    logic                   ready;
    logic [lmed_pkg::PIX_W-1:0] tap_0;
    logic [lmed_pkg::PIX_W-1:0] tap_1;
    logic [lmed_pkg::PIX_W-1:0] tap_2;
    logic [lmed_pkg::PIX_W-1:0] tap_3;
    logic [lmed_pkg::PIX_W-1:0] tap_4;
    logic [lmed_pkg::PIX_W-1:0] tap_5;
    logic [lmed_pkg::PIX_W-1:0] tap_6;
    logic [lmed_pkg::PIX_W-1:0] tap_7;
    logic [lmed_pkg::PIX_W-1:0] tap_8;

    modport source (
        output valid, tap_0, tap_1, tap_2, tap_3, tap_4, tap_5, tap_6, tap_7, tap_8,
        input  ready
    );
    modport sink (
        input  valid, tap_0, tap_1, tap_2, tap_3, tap_4, tap_5, tap_6, tap_7, tap_8,
        output ready
    );
endinterface

interface lmed_med_if;
    logic                   valid;
    logic                   ready;
    logic [lmed_pkg::PIX_W-1:0] median_pixel;

    modport source (
        output valid, median_pixel,
        input  ready
    );
    modport sink (
        input  valid, median_pixel,
        output ready
    );
endinterface

// ----- src/lmed_rank_lane.sv -----
// One rank lane: counts how many window taps order strictly below this lane's tap
// and flags the tap holding the median rank. Depends on lmed_pkg.
`timescale 1ns / 1ps

module lmed_rank_lane #(
    parameter int LANE = 0
) (
    input  lmed_pkg::t_luma_vec i_lum,
    output logic                o_hit
);

    lmed_pkg::t_luma own;
    lmed_pkg::t_rank rank;

    assign own = i_lum[LANE];

    always_comb begin
        rank = '0;
        for (int b = 0; b < lmed_pkg::TAP_COUNT; b++) begin
            // equal luminance: the lower window position ranks lower
            if (b != LANE) begin
                if ((i_lum[b] < own) || ((i_lum[b] == own) && (b < LANE))) begin
                    rank = rank + lmed_pkg::t_rank'(1);
                end
            end
        end
    end

    assign o_hit = (rank == lmed_pkg::t_rank'(lmed_pkg::MEDIAN_RANK));

endmodule

// ----- src/lmed_merge.sv -----
// Merge stage: folds the one-hot lane flags into the selected window pixel.
// Depends on lmed_pkg.
`timescale 1ns / 1ps

module lmed_merge (
    input  lmed_pkg::t_pix_vec i_px,
    input  lmed_pkg::t_hit_vec i_hit,
    output lmed_pkg::t_pix     o_pix
);

    always_comb begin
        o_pix = '0;
        for (int a = 0; a < lmed_pkg::TAP_COUNT; a++) begin
            // exactly one flag is set, so an OR of masked pixels selects it
            o_pix = o_pix | (i_px[a] & {lmed_pkg::PIX_W{i_hit[a]}});
        end
    end

endmodule

// ----- src/luma_median_select_3x3_unit.sv -----
// Top level of the 3x3 luma median select: luminance stage, nine rank lanes,
// merge stage and output register. Depends on lmed_pkg, lmed_if, lmed_rank_lane, lmed_merge.
`timescale 1ns / 1ps

// Usage
// i_win (sink) takes one 3x3 window per transaction, nine packed RGB 8:8:8 taps in
// raster order. o_med (source) returns one transaction per window carrying the
// tap whose luminance 299*R + 587*G + 114*B ranks fifth from the lowest, ties going
// to the lower window position. The pixel is passed through unchanged.
// Pipeline: an input transaction passes the luminance register, the rank register
// and the output register, in that order, before it reaches o_med.
// Throughput: one window per cycle while o_med.ready is high; each tap has its own
// luminance unit and rank lane, so nothing is shared between consecutive windows.
// Stall: when o_med.ready is low the output holds; earlier stages keep filling
// until all three hold a window, and only then i_win.ready drops.
// Reset: i_rst_n (synchronous, active low) empties the pipeline; no windows are lost
// afterwards and no result is produced without an input transaction.
module luma_median_select_3x3_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lmed_win_if.sink   i_win,
    lmed_med_if.source o_med
);

    lmed_pkg::t_pix_vec  in_px;
    lmed_pkg::t_luma_vec in_lum;
    lmed_pkg::t_hit_vec  hit;
    lmed_pkg::t_pix      med;

    logic rdy1, rdy2, rdy3;

    logic                r_v1, r_v2, r_v3;
    lmed_pkg::t_pix_vec  r_px1, r_px2;
    lmed_pkg::t_luma_vec r_lum1;
    lmed_pkg::t_hit_vec  r_hit2;
    lmed_pkg::t_pix      r_med3;

    assign in_px[0] = i_win.tap_0;
    assign in_px[1] = i_win.tap_1;
    assign in_px[2] = i_win.tap_2;
    assign in_px[3] = i_win.tap_3;
    assign in_px[4] = i_win.tap_4;
    assign in_px[5] = i_win.tap_5;
    assign in_px[6] = i_win.tap_6;
    assign in_px[7] = i_win.tap_7;
    assign in_px[8] = i_win.tap_8;

    always_comb begin
        for (int a = 0; a < lmed_pkg::TAP_COUNT; a++) begin
            in_lum[a] = lmed_pkg::luma_of(in_px[a]);
        end
    end

    // a stage advances when it is empty or its successor advances
    assign rdy3 = !r_v3 || o_med.ready;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign i_win.ready = rdy1;

    genvar g;
    generate
        for (g = 0; g < lmed_pkg::TAP_COUNT; g++) begin : g_lane
            lmed_rank_lane #(.LANE(g)) u_lane (
                .i_lum (r_lum1),
                .o_hit (hit[g])
            );
        end
    endgenerate

    lmed_merge u_merge (
        .i_px  (r_px2),
        .i_hit (r_hit2),
        .o_pix (med)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_win.valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_px1  <= in_px;
            r_lum1 <= in_lum;
        end
        if (rdy2) begin
            r_px2  <= r_px1;
            r_hit2 <= hit;
        end
        if (rdy3) begin
            r_med3 <= med;
        end
    end

    assign o_med.valid        = r_v3;
    assign o_med.median_pixel = r_med3;

endmodule
